// ===== design/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// Holds function/operation codes, the back-end state type and the command word.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

    // Request function selector
    typedef enum logic [1:0] {
        FN_PUT   = 2'd0,
        FN_CLEAR = 2'd1,
        FN_READ  = 2'd2
    } tcw_func_t;

    // Classified operation handed from the front end to the back end
    typedef enum logic [2:0] {
        OP_PRINT = 3'd0,
        OP_BKSP  = 3'd1,
        OP_TAB   = 3'd2,
        OP_CR    = 3'd3,
        OP_LF    = 3'd4,
        OP_CLEAR = 3'd5,
        OP_READ  = 3'd6,
        OP_NOP   = 3'd7
    } tcw_op_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_WRITE,
        ST_SCROLL,
        ST_CLEAR,
        ST_READ_WAIT,
        ST_RESULT
    } tcw_state_t;

    // Command queued between front and back
    typedef struct packed {
        tcw_op_t     op;
        logic [15:0] word;   // attribute and character for a print
        logic [10:0] index;  // linear cell address for a read
    } tcw_cmd_t;

    // Character codes
    localparam logic [7:0] CHR_BS    = 8'h08;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_DEL   = 8'h7F;

    // White-on-black space
    localparam logic [15:0] BLANK_CELL = 16'h0F20;

    // Command queue depth
    localparam int QUEUE_DEPTH = 2;

endpackage

// ===== design/tcw_if.sv =====
// Valid/ready channel interfaces for the text console writer.
// tcw_req_if carries requests, tcw_rsp_if carries results. No dependencies.
`timescale 1ns / 1ps

interface tcw_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [3:0]  back_color;
    logic [3:0]  fore_color;
    logic [10:0] cell_index;

    modport source (output valid, func, char_code, back_color, fore_color, cell_index,
                    input ready);
    modport sink   (input valid, func, char_code, back_color, fore_color, cell_index,
                    output ready);
    modport mon    (input valid, ready, func, char_code, back_color, fore_color,
                    cell_index);
endinterface

interface tcw_rsp_if;
    logic        valid;
    logic        ready;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [10:0] cursor_location;
    logic [15:0] cell_data;

    modport source (output valid, cursor_row, cursor_col, cursor_location, cell_data,
                    input ready);
    modport sink   (input valid, cursor_row, cursor_col, cursor_location, cell_data,
                    output ready);
    modport mon    (input valid, ready, cursor_row, cursor_col, cursor_location,
                    cell_data);
endinterface

// ===== design/tcw_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/tcw_front.sv =====
// Front end: accepts request transactions, classifies them into commands
// and holds them in a short queue. Depends on tcw_pkg and tcw_if.
`timescale 1ns / 1ps

module tcw_front (
    input  logic              clk,
    input  logic              rst_n,
    tcw_req_if.sink           request,
    input  logic              init_busy,
    output logic              cmd_valid,
    output tcw_pkg::tcw_cmd_t cmd,
    input  logic              cmd_ready
);

    localparam int PW = $clog2(tcw_pkg::QUEUE_DEPTH);
    localparam int NW = $clog2(tcw_pkg::QUEUE_DEPTH + 1);
    localparam logic [NW-1:0] FULL_COUNT = NW'(tcw_pkg::QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_SLOT  = PW'(tcw_pkg::QUEUE_DEPTH - 1);

    tcw_pkg::tcw_cmd_t q_reg [tcw_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     wptr_reg, wptr_next;
    logic [PW-1:0]     rptr_reg, rptr_next;
    logic [NW-1:0]     count_reg, count_next;

    tcw_pkg::tcw_op_t  op;
    tcw_pkg::tcw_cmd_t new_cmd;
    logic              push;
    logic              pop;

    // Classify the incoming request
    always_comb
    begin
        unique case (tcw_pkg::tcw_func_t'(request.func))
            tcw_pkg::FN_PUT:
            begin
                priority if (request.char_code == tcw_pkg::CHR_BS)  op = tcw_pkg::OP_BKSP;
                else if (request.char_code == tcw_pkg::CHR_TAB)     op = tcw_pkg::OP_TAB;
                else if (request.char_code == tcw_pkg::CHR_CR)      op = tcw_pkg::OP_CR;
                else if (request.char_code == tcw_pkg::CHR_LF)      op = tcw_pkg::OP_LF;
                else if (request.char_code >= tcw_pkg::CHR_SPACE &&
                         request.char_code <= tcw_pkg::CHR_DEL)     op = tcw_pkg::OP_PRINT;
                else                                                op = tcw_pkg::OP_NOP;
            end
            tcw_pkg::FN_CLEAR: op = tcw_pkg::OP_CLEAR;
            tcw_pkg::FN_READ:  op = tcw_pkg::OP_READ;
            default:           op = tcw_pkg::OP_NOP;
        endcase
        new_cmd.op    = op;
        new_cmd.word  = {request.back_color, request.fore_color, request.char_code};
        new_cmd.index = request.cell_index;
    end

    // Queue handshake; no intake during the power-up clearing pass
    assign request.ready = (count_reg != FULL_COUNT) && !init_busy;
    assign push          = request.valid && request.ready;
    assign cmd_valid     = (count_reg != '0);
    assign pop           = cmd_valid && cmd_ready;
    assign cmd           = q_reg[rptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == LAST_SLOT) ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == LAST_SLOT) ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= new_cmd;
        end
    end

endmodule

// ===== design/tcw_back.sv =====
// Back end: carries out queued commands on the cursor and the screen store,
// and registers one result per command. Depends on tcw_pkg, tcw_if, tcw_ram.
`timescale 1ns / 1ps

module tcw_back #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  tcw_pkg::tcw_cmd_t cmd,
    output logic              cmd_ready,
    output logic              init_busy,
    tcw_rsp_if.source         response
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW  = $clog2(CELL_COUNT);
    localparam int RW  = $clog2(ROWS);
    localparam int CW  = $clog2(COLUMNS);
    localparam int TMW = $clog2(TAB_WIDTH);
    localparam logic [AW-1:0]  LAST_CELL  = AW'(CELL_COUNT - 1);
    localparam logic [AW:0]    CELLS_WIDE = (AW+1)'(CELL_COUNT);
    localparam logic [AW-1:0]  ROW_STEP   = AW'(COLUMNS);
    localparam logic [RW-1:0]  LAST_ROW   = RW'(ROWS - 1);
    localparam logic [CW-1:0]  LAST_COL   = CW'(COLUMNS - 1);
    localparam logic [TMW-1:0] LAST_MOD   = TMW'(TAB_WIDTH - 1);

    tcw_pkg::tcw_state_t state_reg, state_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [TMW-1:0] mod_reg, mod_next;      // column modulo tab width
    logic [AW-1:0]  base_reg, base_next;    // store address of the top row
    logic [AW-1:0]  sweep_reg, sweep_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [AW-1:0]  lin_reg, lin_next;
    logic [15:0]    word_reg, word_next;
    logic [15:0]    data_reg, data_next;
    logic           scroll_reg, scroll_next;

    logic           out_valid_reg, out_valid_next;
    logic [4:0]     out_row_reg, out_row_next;
    logic [6:0]     out_col_reg, out_col_next;
    logic [10:0]    out_loc_reg, out_loc_next;
    logic [15:0]    out_data_reg, out_data_next;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [15:0]    ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [15:0]    ram_rdata;

    // Circular row addressing: logical address plus top-row base, modulo store size
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= CELLS_WIDE)
        begin
            s = s - CELLS_WIDE;
        end
        return s[AW-1:0];
    endfunction

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign init_busy = (state_reg == tcw_pkg::ST_INIT);
    assign ram_raddr = wrap_add(AW'(cmd.index), base_reg);

    // Sequencer: next state, cursor update and store access
    always_comb
    begin
        logic        newline;
        logic [31:0] tab_sum;

        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        mod_next       = mod_reg;
        base_next      = base_reg;
        sweep_next     = sweep_reg;
        cnt_next       = cnt_reg;
        lin_next       = lin_reg;
        word_next      = word_reg;
        data_next      = data_reg;
        scroll_next    = scroll_reg;
        out_valid_next = out_valid_reg && !response.ready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_loc_next   = out_loc_reg;
        out_data_next  = out_data_reg;
        cmd_ready      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = sweep_reg;
        ram_wdata      = tcw_pkg::BLANK_CELL;
        newline        = 1'b0;
        tab_sum        = 32'(col_reg) + 32'(TAB_WIDTH) - 32'(mod_reg);

        unique case (state_reg)
            // Power-up blanking of the whole store, no result
            tcw_pkg::ST_INIT:
            begin
                ram_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_CELL)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end

            // Take one command and update the cursor
            tcw_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    data_next   = '0;
                    scroll_next = 1'b0;
                    state_next  = tcw_pkg::ST_RESULT;
                    unique case (cmd.op)
                        tcw_pkg::OP_PRINT:
                        begin
                            lin_next   = AW'(32'(row_reg) * COLUMNS + 32'(col_reg));
                            word_next  = cmd.word;
                            state_next = tcw_pkg::ST_WRITE;
                            if (col_reg == LAST_COL)
                            begin
                                col_next = '0;
                                mod_next = '0;
                                newline  = 1'b1;
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                                mod_next = (mod_reg == LAST_MOD) ? '0 : mod_reg + 1'b1;
                            end
                        end
                        tcw_pkg::OP_BKSP:
                        begin
                            if (col_reg != '0)
                            begin
                                col_next = col_reg - 1'b1;
                                mod_next = (mod_reg == '0) ? LAST_MOD : mod_reg - 1'b1;
                            end
                        end
                        tcw_pkg::OP_TAB:
                        begin
                            mod_next = '0;
                            if (tab_sum >= 32'(COLUMNS))
                            begin
                                col_next = '0;
                                newline  = 1'b1;
                            end
                            else
                            begin
                                col_next = CW'(tab_sum);
                            end
                        end
                        tcw_pkg::OP_CR:
                        begin
                            col_next = '0;
                            mod_next = '0;
                        end
                        tcw_pkg::OP_LF:
                        begin
                            col_next = '0;
                            mod_next = '0;
                            newline  = 1'b1;
                        end
                        tcw_pkg::OP_CLEAR:
                        begin
                            row_next   = '0;
                            col_next   = '0;
                            mod_next   = '0;
                            base_next  = '0;
                            sweep_next = '0;
                            state_next = tcw_pkg::ST_CLEAR;
                        end
                        tcw_pkg::OP_READ:
                        begin
                            if (32'(cmd.index) < CELL_COUNT)
                            begin
                                state_next = tcw_pkg::ST_READ_WAIT;
                            end
                        end
                        tcw_pkg::OP_NOP:
                        begin
                            state_next = tcw_pkg::ST_RESULT;
                        end
                    endcase

                    // Row advance; the bottom row scrolls instead
                    if (newline)
                    begin
                        if (row_reg == LAST_ROW)
                        begin
                            scroll_next = 1'b1;
                            sweep_next  = base_reg;
                            cnt_next    = '0;
                            if (state_next == tcw_pkg::ST_RESULT)
                            begin
                                state_next = tcw_pkg::ST_SCROLL;
                            end
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                end
            end

            // Store the printed character at its old cursor position
            tcw_pkg::ST_WRITE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = wrap_add(lin_reg, base_reg);
                ram_wdata  = word_reg;
                state_next = scroll_reg ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_RESULT;
            end

            // Blank the old top row, then make the next row the top
            tcw_pkg::ST_SCROLL:
            begin
                ram_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == LAST_COL)
                begin
                    base_next  = wrap_add(base_reg, ROW_STEP);
                    state_next = tcw_pkg::ST_RESULT;
                end
            end

            // Blank the whole store for a clear command
            tcw_pkg::ST_CLEAR:
            begin
                ram_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_CELL)
                begin
                    state_next = tcw_pkg::ST_RESULT;
                end
            end

            // Read data from the registered store port arrives in the cycle after the address
            tcw_pkg::ST_READ_WAIT:
            begin
                data_next  = ram_rdata;
                state_next = tcw_pkg::ST_RESULT;
            end

            // Hand the result to the output register once it is free
            tcw_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || response.ready)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = 5'(row_reg);
                    out_col_next   = 7'(col_reg);
                    out_loc_next   = 11'(32'(row_reg) * COLUMNS + 32'(col_reg));
                    out_data_next  = data_reg;
                    state_next     = tcw_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcw_pkg::ST_INIT;
            row_reg       <= '0;
            col_reg       <= '0;
            mod_reg       <= '0;
            base_reg      <= '0;
            sweep_reg     <= '0;
            cnt_reg       <= '0;
            scroll_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            mod_reg       <= mod_next;
            base_reg      <= base_next;
            sweep_reg     <= sweep_next;
            cnt_reg       <= cnt_next;
            scroll_reg    <= scroll_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        lin_reg      <= lin_next;
        word_reg     <= word_next;
        data_reg     <= data_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_loc_reg  <= out_loc_next;
        out_data_reg <= out_data_next;
    end

    assign response.valid           = out_valid_reg;
    assign response.cursor_row      = out_row_reg;
    assign response.cursor_col      = out_col_reg;
    assign response.cursor_location = out_loc_reg;
    assign response.cell_data       = out_data_reg;

endmodule

// ===== design/text_console_writer.sv =====
// Channel    | Dir | Payload                                             | Transaction
// request    | in  | func, char_code, back_color, fore_color, cell_index | valid & ready
// response   | out | cursor_row, cursor_col, cursor_location, cell_data  | valid & ready
//
// From transaction to result, a print or an in-range read passes the queue, one
// sequencer step and a store access; control, ignored and out-of-range reads skip the store access.
// A line that scrolls also blanks one row and moves the top-row base.
// A clear blanks the whole store; one cell is blanked per cycle.
// After reset a clearing pass over all ROWS*COLUMNS cells runs with request.ready low.
// A two-entry command queue lets requests arrive while the back end is busy.
//
// Top level of the text console writer. Depends on tcw_pkg, tcw_if,
// tcw_front, tcw_back and tcw_ram.
`timescale 1ns / 1ps

module text_console_writer #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    tcw_req_if.sink   request,
    tcw_rsp_if.source response
);

    logic              cmd_valid;
    logic              cmd_ready;
    logic              init_busy;
    tcw_pkg::tcw_cmd_t cmd;

    // Intake and classification
    tcw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .init_busy (init_busy),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    // Execution on cursor and screen store
    tcw_back #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .init_busy (init_busy),
        .response  (response)
    );

endmodule

// ===== design/tcw_checker.sv =====
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_if and text_console_writer.
`timescale 1ns / 1ps

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic       clk,
    input logic       rst_n,
    tcw_req_if.sink   request,
    tcw_rsp_if.source response
);

    // A stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid && !response.ready |=>
            response.valid && $stable(response.cursor_row) &&
            $stable(response.cursor_col) && $stable(response.cursor_location) &&
            $stable(response.cell_data))
        else $error("response changed while stalled");

    // Cursor column stays on the screen
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid |-> 32'(response.cursor_col) < COLUMNS)
        else $error("cursor column out of range");

    // Cursor row stays on the screen
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid && (ROWS <= 32) |-> 32'(response.cursor_row) < ROWS)
        else $error("cursor row out of range");

    // Linear location agrees with row and column
    a_location: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid && (ROWS <= 32) |->
            response.cursor_location ==
                11'(32'(response.cursor_row) * COLUMNS + 32'(response.cursor_col)))
        else $error("cursor location does not match row and column");

    // No intake is offered when reset is released, as the store is then being blanked
    a_init_hold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !request.ready)
        else $error("request taken during power-up clearing");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .request  (request),
    .response (response)
);

// ===== sim/tb_text_console_writer.sv =====
// Self-checking testbench for text_console_writer: directed and random console
// traffic with a scoreboard class that models the screen store and cursor.
// Depends on tcw_pkg, tcw_if and the text_console_writer RTL.
`timescale 1ns / 1ps

module tb_text_console_writer;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_WIDTH  = 8;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int RANDOM_ITEMS = 410;
    localparam int HOLD_CYCLES  = 400;

    // Selector value with no operation behind it
    localparam logic [1:0] FN_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  func;
        logic [7:0]  char_code;
        logic [3:0]  back_color;
        logic [3:0]  fore_color;
        logic [10:0] cell_index;
    } console_req_t;

    typedef struct {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [10:0] cursor_location;
        logic [15:0] cell_data;
    } console_rsp_t;

    // Screen and cursor model plus the queue of results still owed by the block
    class console_scoreboard;
        logic [15:0]  cells [CELL_COUNT];
        int           cur_row;
        int           cur_col;
        console_rsp_t owed [$];
        int unsigned  failures;

        function new();
            failures = 0;
            home_and_blank();
        endfunction

        function void home_and_blank();
            foreach (cells[i])
                cells[i] = tcw_pkg::BLANK_CELL;
            cur_row = 0;
            cur_col = 0;
        endfunction

        // Control codes move the cursor, printable codes are stored, the rest do nothing
        function void put_char(logic [7:0] code, logic [3:0] bg, logic [3:0] fg);
            if (code == tcw_pkg::CHR_BS)
            begin
                if (cur_col != 0)
                    cur_col--;
            end
            else if (code == tcw_pkg::CHR_TAB)
            begin
                cur_col = (cur_col / TAB_WIDTH + 1) * TAB_WIDTH;
            end
            else if (code == tcw_pkg::CHR_CR)
            begin
                cur_col = 0;
            end
            else if (code == tcw_pkg::CHR_LF)
            begin
                cur_col = 0;
                cur_row++;
            end
            else if (code >= tcw_pkg::CHR_SPACE && code <= tcw_pkg::CHR_DEL)
            begin
                cells[cur_row * COLUMNS + cur_col] = {bg, fg, code};
                cur_col++;
            end
            // wrap off the right edge
            if (cur_col >= COLUMNS)
            begin
                cur_col = 0;
                cur_row++;
            end
            // scroll up one line at the bottom
            if (cur_row >= ROWS)
            begin
                for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                    cells[i] = cells[i + COLUMNS];
                for (int i = (ROWS - 1) * COLUMNS; i < CELL_COUNT; i++)
                    cells[i] = tcw_pkg::BLANK_CELL;
                cur_row = ROWS - 1;
            end
        endfunction

        function void note_request(console_req_t r);
            console_rsp_t want;
            want.cell_data = '0;
            if (r.func == tcw_pkg::FN_PUT)
                put_char(r.char_code, r.back_color, r.fore_color);
            else if (r.func == tcw_pkg::FN_CLEAR)
                home_and_blank();
            else if (r.func == tcw_pkg::FN_READ && r.cell_index < CELL_COUNT)
                want.cell_data = cells[r.cell_index];
            want.cursor_row      = 5'(cur_row);
            want.cursor_col      = 7'(cur_col);
            want.cursor_location = 11'(cur_row * COLUMNS + cur_col);
            owed.push_back(want);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $error("%s expected %0h actual %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_response(console_rsp_t got);
            console_rsp_t want;
            if (owed.size() == 0)
            begin
                $error("result with nothing owed: row %0d col %0d data %0h",
                       got.cursor_row, got.cursor_col, got.cell_data);
                failures++;
                return;
            end
            want = owed.pop_front();
            compare_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
            compare_field("cursor_col", 16'(want.cursor_col), 16'(got.cursor_col));
            compare_field("cursor_location", 16'(want.cursor_location),
                          16'(got.cursor_location));
            compare_field("cell_data", want.cell_data, got.cell_data);
        endfunction

        function int outstanding();
            return owed.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    tcw_req_if cmd_bus ();
    tcw_rsp_if result_bus ();

    console_scoreboard screen_sb = new();
    console_req_t      stimulus [$];
    int unsigned       requests_taken = 0;
    int unsigned       random_count = 0;
    int unsigned       item_total = 0;

    text_console_writer #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (cmd_bus),
        .response (result_bus)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Watch both channels; results always belong to older requests
    always @(posedge clk)
    begin
        console_req_t r;
        console_rsp_t s;
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                s.cursor_row      = result_bus.cursor_row;
                s.cursor_col      = result_bus.cursor_col;
                s.cursor_location = result_bus.cursor_location;
                s.cell_data       = result_bus.cell_data;
                screen_sb.check_response(s);
            end
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                r.func       = cmd_bus.func;
                r.char_code  = cmd_bus.char_code;
                r.back_color = cmd_bus.back_color;
                r.fore_color = cmd_bus.fore_color;
                r.cell_index = cmd_bus.cell_index;
                screen_sb.note_request(r);
                requests_taken++;
            end
        end
    end

    // Fields that an operation does not use get random values
    function automatic void add_item(logic [1:0] func, logic [7:0] code, logic [3:0] bg,
                                     logic [3:0] fg, logic [10:0] idx);
        console_req_t r;
        r.func       = func;
        r.char_code  = code;
        r.back_color = bg;
        r.fore_color = fg;
        r.cell_index = idx;
        stimulus.push_back(r);
    endfunction

    function automatic void add_put(logic [7:0] code, logic [3:0] bg, logic [3:0] fg);
        add_item(tcw_pkg::FN_PUT, code, bg, fg, 11'($urandom));
    endfunction

    function automatic void add_read(logic [10:0] idx);
        add_item(tcw_pkg::FN_READ, 8'($urandom), 4'($urandom), 4'($urandom), idx);
    endfunction

    function automatic void add_clear();
        add_item(tcw_pkg::FN_CLEAR, 8'($urandom), 4'($urandom), 4'($urandom),
                 11'($urandom));
    endfunction

    // Reads lean toward the rows that see the most writes
    function automatic logic [10:0] pick_cell();
        int k;
        k = $urandom_range(0, 9);
        if (k < 5)
            return 11'($urandom_range(CELL_COUNT - 400, CELL_COUNT - 1));
        else if (k < 7)
            return 11'($urandom_range(0, 3 * COLUMNS - 1));
        else if (k < 9)
            return 11'($urandom_range(0, CELL_COUNT - 1));
        return 11'($urandom_range(CELL_COUNT, 2047));
    endfunction

    // Codes that the block leaves alone: low non-control codes and the upper half
    function automatic logic [7:0] pick_ignored();
        logic [7:0] code;
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(8'h80, 8'hFF));
        do
            code = 8'($urandom_range(0, 8'h1F));
        while (code == tcw_pkg::CHR_BS || code == tcw_pkg::CHR_TAB ||
               code == tcw_pkg::CHR_LF || code == tcw_pkg::CHR_CR);
        return code;
    endfunction

    task automatic build_directed();
        add_put(8'h41, 4'hF, 4'hF);
        add_put(tcw_pkg::CHR_SPACE, 4'h0, 4'h0);
        add_put(tcw_pkg::CHR_DEL, 4'hA, 4'h5);
        add_read(11'd0);
        add_read(11'd2);
        add_put(8'h1F, 4'h3, 4'h3);
        add_put(8'h80, 4'h3, 4'h3);
        add_put(8'hFF, 4'h3, 4'h3);
        add_put(8'h00, 4'h3, 4'h3);
        add_put(tcw_pkg::CHR_BS, 4'h1, 4'h2);
        add_put(tcw_pkg::CHR_CR, 4'h1, 4'h2);
        add_put(tcw_pkg::CHR_BS, 4'h1, 4'h2);     // already at column zero
        add_put(tcw_pkg::CHR_TAB, 4'h1, 4'h2);
        add_put(tcw_pkg::CHR_TAB, 4'h1, 4'h2);
        add_put(tcw_pkg::CHR_LF, 4'h1, 4'h2);
        add_read(11'd1999);
        add_read(11'd2000);              // just past the screen
        add_read(11'h7FF);
        add_item(FN_UNUSED, 8'h41, 4'hF, 4'hF, 11'h7FF);
        add_clear();
        add_read(11'd0);
        add_put(8'h7A, 4'h3, 4'hC);
        add_read(11'd0);
    endtask

    // Mostly lines of text ended by a line feed, with reads, tab runs and noise mixed in
    task automatic build_random();
        int         pick;
        int         len;
        int         s;
        bit         cleared;
        logic [3:0] bg;
        logic [3:0] fg;
        cleared = 1'b0;
        while (random_count < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (!cleared && random_count > 250)
            begin
                add_clear();
                cleared = 1'b1;
                random_count++;
            end
            else if (pick < 75)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 95)
                                                  : $urandom_range(0, 10);
                bg = 4'($urandom);
                fg = 4'($urandom);
                for (int i = 0; i < len; i++)
                begin
                    s = $urandom_range(0, 99);
                    if (s < 80)
                    begin
                        add_put(8'($urandom_range(tcw_pkg::CHR_SPACE, tcw_pkg::CHR_DEL)),
                                bg, fg);
                        random_count++;
                    end
                    else if (s < 86)
                    begin
                        add_put(tcw_pkg::CHR_BS, bg, fg);
                        random_count++;
                    end
                    else if (s < 91)
                    begin
                        add_put(tcw_pkg::CHR_TAB, bg, fg);
                        random_count++;
                    end
                    else if (s < 93)
                    begin
                        add_put(tcw_pkg::CHR_CR, bg, fg);
                        random_count++;
                    end
                    else if (s < 96)
                    begin
                        add_read(pick_cell());
                        random_count++;
                    end
                    else
                    begin
                        add_put(pick_ignored(), 4'($urandom), 4'($urandom));
                    end
                end
                if ($urandom_range(0, 99) < 85)
                begin
                    add_put(tcw_pkg::CHR_LF, 4'($urandom), 4'($urandom));
                    random_count++;
                end
            end
            else if (pick < 90)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    add_read(pick_cell());
                    random_count++;
                end
            end
            else if (pick < 94)
            begin
                add_item(FN_UNUSED, 8'($urandom), 4'($urandom), 4'($urandom),
                         11'($urandom));
            end
            else
            begin
                repeat ($urandom_range(1, 11))
                begin
                    add_put(tcw_pkg::CHR_TAB, 4'($urandom), 4'($urandom));
                    random_count++;
                end
            end
        end
    endtask

    // Sender: bursts of back-to-back transactions separated by random gaps
    task automatic drive_requests();
        console_req_t r;
        int           burst_left;
        int           gap;
        int unsigned  sent;
        burst_left = 0;
        sent = 0;
        while (stimulus.size() > 0)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                if (sent > 150 && sent < 230)
                    gap = 0;
                else if ($urandom_range(0, 19) == 0)
                    gap = $urandom_range(20, 60);
                else if ($urandom_range(0, 2) == 0)
                    gap = 0;
                else
                    gap = $urandom_range(1, 8);
                if (gap > 0)
                begin
                    cmd_bus.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            r = stimulus.pop_front();
            cmd_bus.valid      <= 1'b1;
            cmd_bus.func       <= r.func;
            cmd_bus.char_code  <= r.char_code;
            cmd_bus.back_color <= r.back_color;
            cmd_bus.fore_color <= r.fore_color;
            cmd_bus.cell_index <= r.cell_index;
            do
                @(posedge clk);
            while (cmd_bus.ready !== 1'b1);
            burst_left--;
            sent++;
        end
        cmd_bus.valid <= 1'b0;
    endtask

    // Receiver: rotating stall patterns, plus one long hold-off to back up the block
    initial
    begin
        int unsigned cyc;
        bit          held;
        int          phase;
        cyc = 0;
        held = 1'b0;
        result_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (!held && requests_taken >= 80)
            begin
                held = 1'b1;
                result_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                phase = (cyc / 97) % 4;
                unique case (phase)
                    0: result_bus.ready <= 1'b1;
                    1: result_bus.ready <= 1'($urandom_range(0, 1));
                    2: result_bus.ready <= ((cyc % 7) >= 3);
                    default: result_bus.ready <= ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n              <= 1'b0;
        cmd_bus.valid      <= 1'b0;
        cmd_bus.func       <= tcw_pkg::FN_PUT;
        cmd_bus.char_code  <= '0;
        cmd_bus.back_color <= '0;
        cmd_bus.fore_color <= '0;
        cmd_bus.cell_index <= '0;
        build_directed();
        build_random();
        item_total = stimulus.size();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        drive_requests();
        while (requests_taken < item_total || screen_sb.outstanding() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (screen_sb.failures == 0 && screen_sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog, sized for every item being a full-screen clear plus receiver stalls
    initial
    begin
        #60_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tcw_pkg.sv
design/tcw_if.sv
design/tcw_ram.sv
design/tcw_front.sv
design/tcw_back.sv
design/text_console_writer.sv
design/tcw_checker.sv
sim/tb_text_console_writer.sv
